// ----- src/potw_pkg.sv -----
package potw_pkg;

  localparam int CordicSteps = 18;
  localparam int XyW = 35;
  localparam int ZW = 27;
  localparam int CsW = 23;

  localparam logic signed [16:0] FullTurn = 17'sd23040;
  localparam logic signed [16:0] TwoTurns = 17'sd46080;
  localparam logic signed [16:0] HalfTurn = 17'sd11520;
  localparam logic signed [16:0] ThreeHalfTurns = 17'sd34560;
  localparam logic signed [16:0] QuarterTurn = 17'sd5760;
  localparam logic [14:0] DefaultDistance = 15'd25600;
  localparam logic signed [XyW-1:0] CordicX0 = 35'sd652032874;
  localparam logic signed [21:0] PiOver11520Q32 = 22'sd1171271;

  localparam logic [2:0] SeenFull = 3'd4;
  localparam logic [2:0] SeenDistDir = 3'd2;
  localparam logic [2:0] SeenDir = 3'd1;

  typedef logic signed [ZW-1:0] atan_tab_t [CordicSteps];
  localparam atan_tab_t AtanTab = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379, 27'sd117304,
    27'sd58666, 27'sd29335, 27'sd14668, 27'sd7334, 27'sd3667, 27'sd1833,
    27'sd917, 27'sd458, 27'sd229, 27'sd115, 27'sd57, 27'sd29
  };

  typedef struct packed {
    logic [14:0] rng;
    logic signed [15:0] dr;
    logic signed [14:0] w;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pvx;
    logic signed [15:0] pvy;
    logic neg;
  } carry_t;

  function automatic logic signed [15:0] clamp16(input logic signed [25:0] v);
    if (v > 26'sd32767) begin
      return 16'sh7fff;
    end else if (v < -26'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic logic clipped(input logic signed [25:0] v);
    return (v > 26'sd32767) || (v < -26'sd32768);
  endfunction

endpackage

// ----- src/polar_observation_to_world_core.sv -----
// polar_observation_to_world_core
// turns a relative polar sighting plus the observer pose and velocity into an
// absolute position and velocity, saturated to 16 bits.
// input: drive the in_ fields and raise start for one cycle; the item is taken
// at that edge when busy is low. busy is low whenever reset is released, so a
// new item may be started in every cycle.
// output: out_valid strobes for one cycle with the out_ fields of one item;
// the receiver cannot stall, items leave in the order they came in.
// pipeline: one item per cycle, through an input register, the
// 18-stage cordic pipeline and five multiply and rounding stages.
// reset: synchronous, active low; clears every valid bit so items in flight
// are dropped, data registers are not cleared.
module polar_observation_to_world_core
  import potw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [2:0] in_values_seen,
  input  logic [14:0] in_seen_distance,
  input  logic signed [14:0] in_seen_direction,
  input  logic signed [15:0] in_distance_change,
  input  logic signed [14:0] in_direction_change,
  input  logic signed [15:0] in_player_x,
  input  logic signed [15:0] in_player_y,
  input  logic signed [14:0] in_body_angle,
  input  logic signed [14:0] in_head_angle,
  input  logic signed [15:0] in_player_vx,
  input  logic signed [15:0] in_player_vy,
  output logic out_valid,
  output logic signed [15:0] out_object_x,
  output logic signed [15:0] out_object_y,
  output logic signed [15:0] out_object_vx,
  output logic signed [15:0] out_object_vy,
  output logic out_saturated
);

  assign busy = ~rst_n;

  // input stage: select fields, wrap and fold the angle
  logic [14:0] dist_sel;
  logic signed [14:0] dir_sel;
  logic signed [15:0] dr_sel;
  logic signed [14:0] w_sel;
  logic signed [16:0] ang_sum, ang_wrap, ang_fold;
  logic fold_neg;
  carry_t carry_nxt;

  always_comb begin
    dist_sel = DefaultDistance;
    dir_sel = '0;
    dr_sel = '0;
    w_sel = '0;
    case (in_values_seen)
      SeenFull: begin
        dist_sel = in_seen_distance;
        dir_sel = in_seen_direction;
        dr_sel = in_distance_change;
        w_sel = in_direction_change;
      end
      SeenDistDir: begin
        dist_sel = in_seen_distance;
        dir_sel = in_seen_direction;
      end
      SeenDir: begin
        dir_sel = in_seen_direction;
      end
      default: begin
        dist_sel = DefaultDistance;
      end
    endcase
    ang_sum = 17'(in_body_angle) + 17'(in_head_angle) - 17'(dir_sel);
    if (ang_sum > ThreeHalfTurns) begin
      ang_wrap = ang_sum - TwoTurns;
    end else if (ang_sum > HalfTurn) begin
      ang_wrap = ang_sum - FullTurn;
    end else if (ang_sum <= -ThreeHalfTurns) begin
      ang_wrap = ang_sum + TwoTurns;
    end else if (ang_sum <= -HalfTurn) begin
      ang_wrap = ang_sum + FullTurn;
    end else begin
      ang_wrap = ang_sum;
    end
    fold_neg = 1'b0;
    ang_fold = ang_wrap;
    if (ang_wrap > QuarterTurn) begin
      ang_fold = ang_wrap - HalfTurn;
      fold_neg = 1'b1;
    end else if (ang_wrap < -QuarterTurn) begin
      ang_fold = ang_wrap + HalfTurn;
      fold_neg = 1'b1;
    end
    carry_nxt = '{rng: dist_sel, dr: dr_sel, w: w_sel, px: in_player_x, py: in_player_y,
                  pvx: in_player_vx, pvy: in_player_vy, neg: fold_neg};
  end

  logic vld_r [CordicSteps+1];
  logic signed [XyW-1:0] x_r [CordicSteps+1];
  logic signed [XyW-1:0] y_r [CordicSteps+1];
  logic signed [ZW-1:0] z_r [CordicSteps+1];
  carry_t cy_r [CordicSteps+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= start;
    end
    x_r[0] <= CordicX0;
    y_r[0] <= '0;
    z_r[0] <= ZW'(ang_fold) <<< 10;
    cy_r[0] <= carry_nxt;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - AtanTab[i];
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + AtanTab[i];
      end
      cy_r[i+1] <= cy_r[i];
    end
  end

  // q1: unfold and round to q20, start tangential product
  logic signed [XyW-1:0] xn, yn, xr, yr;
  logic signed [15:0] dist_s;
  always_comb begin
    xn = cy_r[CordicSteps].neg ? -x_r[CordicSteps] : x_r[CordicSteps];
    yn = cy_r[CordicSteps].neg ? -y_r[CordicSteps] : y_r[CordicSteps];
    xr = (xn + XyW'(512)) >>> 10;
    yr = (yn + XyW'(512)) >>> 10;
    dist_s = {1'b0, cy_r[CordicSteps].rng};
  end

  logic q1_vld_r;
  logic signed [CsW-1:0] q1_c_r, q1_s_r;
  logic signed [30:0] q1_t_r;
  carry_t q1_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_vld_r <= 1'b0;
    end else begin
      q1_vld_r <= vld_r[CordicSteps];
    end
    q1_c_r <= xr[CsW-1:0];
    q1_s_r <= yr[CsW-1:0];
    q1_t_r <= 31'(dist_s * cy_r[CordicSteps].w);
    q1_cy_r <= cy_r[CordicSteps];
  end

  // q2: products
  logic signed [15:0] q1_dist_s;
  assign q1_dist_s = {1'b0, q1_cy_r.rng};

  logic q2_vld_r;
  logic signed [38:0] q2_pc_r, q2_ps_r;
  logic signed [38:0] q2_rc_r, q2_rs_r;
  logic signed [53:0] q2_tk_r;
  logic signed [CsW-1:0] q2_c_r, q2_s_r;
  carry_t q2_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_vld_r <= 1'b0;
    end else begin
      q2_vld_r <= q1_vld_r;
    end
    q2_pc_r <= 39'(q1_dist_s * q1_c_r);
    q2_ps_r <= 39'(q1_dist_s * q1_s_r);
    q2_rc_r <= 39'(q1_cy_r.dr * q1_c_r);
    q2_rs_r <= 39'(q1_cy_r.dr * q1_s_r);
    q2_tk_r <= 54'(q1_t_r * PiOver11520Q32);
    q2_c_r <= q1_c_r;
    q2_s_r <= q1_s_r;
    q2_cy_r <= q1_cy_r;
  end

  // q3: positions, tangential speed in q12
  logic signed [38:0] pc_rnd, ps_rnd;
  logic signed [25:0] pos_x, pos_y;
  logic signed [53:0] tk_rnd;
  always_comb begin
    pc_rnd = (q2_pc_r + 39'sd524288) >>> 20;
    ps_rnd = (q2_ps_r + 39'sd524288) >>> 20;
    pos_x = 26'(pc_rnd) + 26'(q2_cy_r.px);
    pos_y = 26'(ps_rnd) + 26'(q2_cy_r.py);
    tk_rnd = (q2_tk_r + 54'sd524288) >>> 20;
  end

  logic q3_vld_r;
  logic signed [15:0] q3_ox_r, q3_oy_r;
  logic q3_sat_r;
  logic signed [31:0] q3_tq_r;
  logic signed [38:0] q3_rc_r, q3_rs_r;
  logic signed [CsW-1:0] q3_c_r, q3_s_r;
  logic signed [15:0] q3_pvx_r, q3_pvy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q3_vld_r <= 1'b0;
    end else begin
      q3_vld_r <= q2_vld_r;
    end
    q3_ox_r <= clamp16(pos_x);
    q3_oy_r <= clamp16(pos_y);
    q3_sat_r <= clipped(pos_x) | clipped(pos_y);
    q3_tq_r <= tk_rnd[31:0];
    q3_rc_r <= q2_rc_r;
    q3_rs_r <= q2_rs_r;
    q3_c_r <= q2_c_r;
    q3_s_r <= q2_s_r;
    q3_pvx_r <= q2_cy_r.pvx;
    q3_pvy_r <= q2_cy_r.pvy;
  end

  // q4: tangential products
  logic q4_vld_r;
  logic signed [55:0] q4_tqs_r, q4_tqc_r;
  logic signed [38:0] q4_rc_r, q4_rs_r;
  logic signed [15:0] q4_ox_r, q4_oy_r, q4_pvx_r, q4_pvy_r;
  logic q4_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q4_vld_r <= 1'b0;
    end else begin
      q4_vld_r <= q3_vld_r;
    end
    q4_tqs_r <= 56'(q3_tq_r * q3_s_r);
    q4_tqc_r <= 56'(q3_tq_r * q3_c_r);
    q4_rc_r <= q3_rc_r;
    q4_rs_r <= q3_rs_r;
    q4_ox_r <= q3_ox_r;
    q4_oy_r <= q3_oy_r;
    q4_pvx_r <= q3_pvx_r;
    q4_pvy_r <= q3_pvy_r;
    q4_sat_r <= q3_sat_r;
  end

  // q5: velocity sums and output register
  logic signed [55:0] vrx, vry, vrx_rnd, vry_rnd;
  logic signed [25:0] vel_x, vel_y;
  always_comb begin
    vrx = (56'(q4_rc_r) <<< 12) - q4_tqs_r;
    vry = (56'(q4_rs_r) <<< 12) + q4_tqc_r;
    vrx_rnd = (vrx + 56'sd2147483648) >>> 32;
    vry_rnd = (vry + 56'sd2147483648) >>> 32;
    vel_x = 26'(vrx_rnd) + 26'(q4_pvx_r);
    vel_y = 26'(vry_rnd) + 26'(q4_pvy_r);
  end

  logic out_valid_r, out_sat_r;
  logic signed [15:0] out_x_r, out_y_r, out_vx_r, out_vy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_sat_r <= 1'b0;
    end else begin
      out_valid_r <= q4_vld_r;
      out_sat_r <= q4_vld_r & (q4_sat_r | clipped(vel_x) | clipped(vel_y));
    end
    out_x_r <= q4_ox_r;
    out_y_r <= q4_oy_r;
    out_vx_r <= clamp16(vel_x);
    out_vy_r <= clamp16(vel_y);
  end

  assign out_valid = out_valid_r;
  assign out_saturated = out_sat_r;
  assign out_object_x = out_x_r;
  assign out_object_y = out_y_r;
  assign out_object_vx = out_vx_r;
  assign out_object_vy = out_vy_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, 24))
    else $error("result without an item 24 cycles earlier");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (z_r[0] <= 27'sd5898240 && z_r[0] >= -27'sd5898240))
    else $error("folded angle out of range");

  a_sat_gated: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_saturated)
    else $error("saturated flag without a result");

  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[CordicSteps] |=> q1_vld_r)
    else $error("item lost after cordic");
`endif

endmodule
